// ----- hw/rtl/brar_pkg.sv -----
// brar_pkg: shared types and constants for the bit array range rotate unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package brar_pkg;

	localparam int WORD_W       = 64;     // bits per store word
	localparam int BIT_W        = 6;      // log2(WORD_W)
	localparam int IDX_W        = 13;     // bit index width inside a range
	localparam int SZ_W         = 17;     // width for size compares
	localparam int MAX_BITS_DEF = 4096;
	localparam logic [12:0] ARRAY_BITS_RST = 13'd4096;

	localparam logic [1:0] CMD_READ    = 2'd0;
	localparam logic [1:0] CMD_WRITE   = 2'd1;
	localparam logic [1:0] CMD_ROTATE  = 2'd2;
	localparam logic [1:0] CMD_REVERSE = 2'd3;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [11:0]        bit_position;
		logic [12:0]        range_length;
		logic signed [15:0] shift_amount;
		logic               write_value;
	} req_t;

	typedef struct packed {
		logic read_value;
		logic range_error;
	} rsp_t;

endpackage
`default_nettype wire

// ----- hw/rtl/brar_mem.sv -----
// brar_mem: word store, one write port, two registered read ports.
// Depends on brar_pkg.
`timescale 1ns / 1ps
`default_nettype none
module brar_mem #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  wire                              clk,
	input  wire                              we,
	input  wire  [AW-1:0]                    waddr,
	input  wire  [brar_pkg::WORD_W-1:0]      wdata,
	input  wire  [AW-1:0]                    raddr_a,
	input  wire  [AW-1:0]                    raddr_b,
	output logic [brar_pkg::WORD_W-1:0]      rdata_a,
	output logic [brar_pkg::WORD_W-1:0]      rdata_b
);

	logic [brar_pkg::WORD_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule
`default_nettype wire

// ----- hw/rtl/brar_mod.sv -----
// brar_mod: iterative restoring remainder, 16-bit dividend by 13-bit divisor.
// Uses nothing from brar_pkg; one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module brar_mod (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	input  wire  [15:0] dividend,
	input  wire  [12:0] divisor,
	output logic        busy,
	output logic        done,
	output logic [12:0] rem
);

	logic [15:0] dvd_q;
	logic [12:0] dvs_q;
	logic [13:0] rem_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [13:0] shl;
	logic [13:0] sub;

	assign shl  = {rem_q[12:0], dvd_q[15]};
	assign sub  = shl - {1'b0, dvs_q};
	assign busy = busy_q;
	assign done = done_q;
	assign rem  = rem_q[12:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd16;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[14:0], 1'b0};
			rem_q <= (shl >= {1'b0, dvs_q}) ? sub : shl;
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/bit_array_range_rotate_unit.sv -----
// Bit array range rotate unit: packed bit store with read, write, range
// reverse and range rotate (three reversals). Depends on brar_pkg,
// brar_mem and brar_mod.
// Flow: an error or empty range is answered from idle; read/write go through S_RW; reverse
// swaps len/2 bit pairs (S_SWRD, S_SWW1, S_SWW2 if two words) through the store's single
// write port; rotate first runs the remainder unit (S_DIVGO, S_DIV), then three passes.
// One transaction at a time; busy is high until the result strobe (an error or empty range never raises it).
// Reset: asynchronous; afterward a clearing pass zeroes every store word
// while busy is high. The receiver cannot stall results.
`timescale 1ns / 1ps
`default_nettype none
module bit_array_range_rotate_unit #(
	parameter int MAX_BITS = brar_pkg::MAX_BITS_DEF
) (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             start,
	output logic            busy,
	input  wire brar_pkg::req_t req,
	output logic            done,
	output brar_pkg::rsp_t  rsp,
	input  wire             cfg_we,
	input  wire  [12:0]     cfg_wdata
);

	localparam int NWORDS = (MAX_BITS + brar_pkg::WORD_W - 1) / brar_pkg::WORD_W;
	localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
	localparam int IW     = brar_pkg::IDX_W;

	// controller states
	localparam logic [3:0] S_CLR   = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_RW    = 4'd2;
	localparam logic [3:0] S_DIVGO = 4'd3;
	localparam logic [3:0] S_DIV   = 4'd4;
	localparam logic [3:0] S_SETUP = 4'd5;
	localparam logic [3:0] S_SWRD  = 4'd6;
	localparam logic [3:0] S_SWW1  = 4'd7;
	localparam logic [3:0] S_SWW2  = 4'd8;

	function automatic logic [AW-1:0] word_of(input logic [IW-1:0] idx);
		logic [IW+AW-1:0] t;
		t = {{AW{1'b0}}, idx} >> brar_pkg::BIT_W;
		return t[AW-1:0];
	endfunction

	logic [3:0]        state_q;
	logic [12:0]       array_bits_q;
	logic [AW-1:0]     clr_q;
	brar_pkg::req_t    req_q;
	logic [IW-1:0]     lo_q, hi_q;
	logic [IW-1:0]     left_q;
	logic [1:0]        pass_q;
	logic [brar_pkg::WORD_W-1:0] hold_q;
	logic              done_q;
	brar_pkg::rsp_t    rsp_q;

	// size in use = min(array_bits, MAX_BITS)
	logic [brar_pkg::SZ_W-1:0] size;
	logic [brar_pkg::SZ_W-1:0] pos_x, end_x;
	logic                      err_in, empty_in;

	assign size  = (brar_pkg::SZ_W'(array_bits_q) > brar_pkg::SZ_W'(MAX_BITS)) ?
		brar_pkg::SZ_W'(MAX_BITS) : brar_pkg::SZ_W'(array_bits_q);
	assign pos_x = brar_pkg::SZ_W'(req.bit_position);
	assign end_x = pos_x + brar_pkg::SZ_W'(req.range_length);

	always_comb begin
		empty_in = 1'b0;
		err_in   = 1'b0;
		if (req.cmd == brar_pkg::CMD_READ || req.cmd == brar_pkg::CMD_WRITE) begin
			err_in = (pos_x >= size);
		end else if (req.range_length == 13'd0) begin
			empty_in = 1'b1;
		end else begin
			err_in = (end_x > size);
		end
	end

	// memory ports
	logic                        we;
	logic [AW-1:0]               waddr, raddr_a, raddr_b;
	logic [brar_pkg::WORD_W-1:0] wdata, rdata_a, rdata_b;

	brar_mem #(.DEPTH(NWORDS), .AW(AW)) u_mem (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr_a(raddr_a), .raddr_b(raddr_b),
		.rdata_a(rdata_a), .rdata_b(rdata_b)
	);

	// remainder of |shift| by the range length
	logic        div_start, div_busy, div_done;
	logic [12:0] div_rem;
	logic [15:0] mag;

	assign mag = req_q.shift_amount[15] ? 16'(~req_q.shift_amount + 16'sd1) :
		16'(req_q.shift_amount);
	assign div_start = (state_q == S_DIVGO);

	brar_mod u_mod (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(mag),
		.divisor(req_q.range_length), .busy(div_busy), .done(div_done),
		.rem(div_rem)
	);

	// current reversal pass: (pos,left), (pos+left,len-left), (pos,len)
	logic [IW-1:0] p_off, p_len;
	always_comb begin
		case (pass_q)
			2'd0: begin
				p_off = IW'(req_q.bit_position);
				p_len = left_q;
			end
			2'd1: begin
				p_off = IW'(req_q.bit_position) + left_q;
				p_len = req_q.range_length - left_q;
			end
			default: begin
				p_off = IW'(req_q.bit_position);
				p_len = req_q.range_length;
			end
		endcase
	end

	logic [brar_pkg::BIT_W-1:0] lo_b, hi_b;
	logic                       same_word;
	logic                       bit_lo, bit_hi;
	logic [brar_pkg::WORD_W-1:0] wa_new, wb_new, rw_word;

	assign lo_b      = lo_q[brar_pkg::BIT_W-1:0];
	assign hi_b      = hi_q[brar_pkg::BIT_W-1:0];
	assign same_word = (word_of(lo_q) == word_of(hi_q));
	assign bit_lo    = rdata_a[lo_b];
	assign bit_hi    = rdata_b[hi_b];

	always_comb begin
		wa_new       = rdata_a;
		wa_new[lo_b] = bit_hi;
		if (same_word) begin
			wa_new[hi_b] = bit_lo;
		end
		wb_new       = rdata_b;
		wb_new[hi_b] = bit_lo;
		rw_word       = rdata_a;
		rw_word[lo_b] = req_q.write_value;
	end

	// memory access steering
	always_comb begin
		raddr_a = word_of(lo_q);
		raddr_b = word_of(hi_q);
		we      = 1'b0;
		waddr   = word_of(lo_q);
		wdata   = wa_new;
		case (state_q)
			S_CLR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = '0;
			end
			S_IDLE: begin
				raddr_a = word_of(IW'(req.bit_position));
			end
			S_RW: begin
				we    = (req_q.cmd == brar_pkg::CMD_WRITE);
				wdata = rw_word;
			end
			S_SWW1: begin
				we = 1'b1;
			end
			S_SWW2: begin
				we    = 1'b1;
				waddr = word_of(hi_q);
				wdata = hold_q;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLR;
			array_bits_q <= brar_pkg::ARRAY_BITS_RST;
			clr_q        <= '0;
			pass_q       <= '0;
			done_q       <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				array_bits_q <= cfg_wdata;
			end
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(NWORDS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						if (err_in || empty_in) begin
							done_q <= 1'b1;
						end else if (req.cmd == brar_pkg::CMD_ROTATE) begin
							state_q <= S_DIVGO;
						end else if (req.cmd == brar_pkg::CMD_REVERSE) begin
							pass_q  <= 2'd2;
							state_q <= S_SETUP;
						end else begin
							state_q <= S_RW;
						end
					end
				end
				S_RW: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_DIVGO: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_done) begin
						pass_q  <= 2'd0;
						state_q <= S_SETUP;
					end
				end
				S_SETUP: begin
					if (p_len < IW'(2)) begin
						if (pass_q == 2'd2) begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							pass_q <= pass_q + 2'd1;
						end
					end else begin
						state_q <= S_SWRD;
					end
				end
				S_SWRD: begin
					if (lo_q >= hi_q) begin
						if (pass_q == 2'd2) begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							pass_q  <= pass_q + 2'd1;
							state_q <= S_SETUP;
						end
					end else begin
						state_q <= S_SWW1;
					end
				end
				S_SWW1: begin
					state_q <= same_word ? S_SWRD : S_SWW2;
				end
				S_SWW2: begin
					state_q <= S_SWRD;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					req_q             <= req;
					lo_q              <= IW'(req.bit_position);
					rsp_q.read_value  <= 1'b0;
					rsp_q.range_error <= err_in;
				end
			end
			S_RW: begin
				if (req_q.cmd == brar_pkg::CMD_READ) begin
					rsp_q.read_value <= bit_lo;
				end
			end
			S_DIV: begin
				if (div_done) begin
					// left rotation amount that equals the requested one
					if (req_q.shift_amount[15]) begin
						left_q <= div_rem;
					end else begin
						left_q <= (div_rem == 13'd0) ? '0 : req_q.range_length - div_rem;
					end
				end
			end
			S_SETUP: begin
				lo_q <= p_off;
				hi_q <= p_off + p_len - IW'(1);
			end
			S_SWW1: begin
				hold_q <= wb_new;
				if (same_word) begin
					lo_q <= lo_q + IW'(1);
					hi_q <= hi_q - IW'(1);
				end
			end
			S_SWW2: begin
				lo_q <= lo_q + IW'(1);
				hi_q <= hi_q - IW'(1);
			end
			default: begin
				hold_q <= hold_q;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

`ifndef ASSERT_OFF
	// a result only follows an accepted or running transaction
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy) || $past(start))
		else $error("result strobe without a transaction");

	// a failed transaction never returns a read bit
	a_err_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.range_error |-> !rsp.read_value)
		else $error("read value set on range error");

	// the store is written only while the unit is busy
	a_we_busy: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> busy)
		else $error("store write while idle");

	// the remainder unit runs only inside a rotate
	a_div_in_rot: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> state_q == S_DIV)
		else $error("remainder unit active outside rotate");
`endif

endmodule
`default_nettype wire
